// ----- sv/psc_pkg.sv -----
// shared types, codes and helper functions of the packet scrambler
package psc_pkg;

  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned REM_BITS    = LENGTH_BITS + 1;
  localparam int unsigned IN_BYTES    = (LENGTH_BITS + 72 + 7) / 8;
  localparam int unsigned IN_TDATA_W  = IN_BYTES * 8;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  // item kind
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // operating mode
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_KEY = 2'd2;

  // header handling codes
  localparam logic [2:0] HS_NONE     = 3'd0;
  localparam logic [2:0] HS_PAD_BYTE = 3'd1;
  localparam logic [2:0] HS_ACC_OUT  = 3'd2;
  localparam logic [2:0] HS_PAD_WORD = 3'd3;
  localparam logic [2:0] HS_PAD_PEND = 3'd6;
  localparam logic [2:0] HS_SALT     = 3'd7;

  typedef struct packed {
    logic                   op;
    logic [LENGTH_BITS-1:0] length;
    logic [31:0]            random_value;
    logic [7:0]             count_in;
    logic [31:0]            data_in;
  } item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [3:0]  byte_mask;
    logic [7:0]  count_out;
    logic        last;
  } result_t;

  function automatic logic [31:0] rotl32(input logic [31:0] w, input logic [4:0] r);
    logic [63:0] t;
    t = {w, w} << r;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] w, input logic [4:0] r);
    logic [63:0] t;
    t = {w, w} >> r;
    return t[31:0];
  endfunction

endpackage

// ----- sv/psc_in_reg.sv -----
// input register stage holding one accepted item
module psc_in_reg
  import psc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- sv/psc_core.sv -----
// configuration registers, packet state and per-item scramble / descramble step
module psc_core
  import psc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  fire,
  input  item_t                 item,
  output logic                  res_valid,
  output result_t               res
);

  logic                mode_r, mode_nxt;
  logic [31:0]         xor_key_r, xor_key_nxt;
  logic [4:0]          shift_key_r, shift_key_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [1:0]          pos_r, pos_nxt;
  logic [REM_BITS-1:0] rem_r, rem_nxt;
  logic [31:0]         mask_r, mask_nxt;
  logic [4:0]          rot_r, rot_nxt;
  logic [2:0]          hs_r, hs_nxt;
  logic                in_packet_r, in_packet_nxt;

  logic [LENGTH_BITS-1:0] len_e;
  logic [REM_BITS-1:0]    sum2;
  logic [1:0]             pad_k;
  logic [REM_BITS-1:0]    body;
  logic [31:0]            body32;
  logic [31:0]            acc_w;
  logic [1:0]             pos_w;
  logic [REM_BITS-1:0]    rem_w;
  logic                   emitted;
  logic                   last_w;
  logic [31:0]            dword;
  logic [2:0]             nb;
  logic [3:0]             valid_m;
  logic [3:0]             pm;
  logic [1:0]             kd;
  logic [1:0]             kd1;

  always_comb begin
    mode_nxt      = mode_r;
    xor_key_nxt   = xor_key_r;
    shift_key_nxt = shift_key_r;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    mask_nxt      = mask_r;
    rot_nxt       = rot_r;
    hs_nxt        = hs_r;
    in_packet_nxt = in_packet_r;
    res_valid     = 1'b0;
    res           = '0;

    len_e   = (item.length == '0) ? LENGTH_BITS'(1) : item.length;
    sum2    = {1'b0, len_e} + REM_BITS'(2);
    pad_k   = 2'(~sum2[1:0] + 2'd1);
    body    = sum2 + REM_BITS'(pad_k);
    body32  = 32'(body);
    acc_w   = acc_r;
    pos_w   = pos_r;
    rem_w   = rem_r;
    emitted = 1'b0;
    last_w  = 1'b0;
    dword   = rotr32(item.data_in, rot_r) ^ mask_r;
    nb      = (rem_r >= REM_BITS'(4)) ? 3'd4 : rem_r[2:0];
    valid_m = 4'((5'd1 << nb) - 5'd1);
    pm      = 4'hF;
    kd      = dword[1:0];
    kd1     = kd + 2'd1;

    if (fire) begin
      if (item.op == OP_START) begin
        if (mode_r == MODE_ENC) begin
          mask_nxt = body32 ^ xor_key_r ^ item.random_value;
          rot_nxt  = body[4:0] ^ shift_key_r ^ item.random_value[4:0];
          unique case (pad_k)
            2'd0: begin
              acc_nxt = {16'd0, item.count_in, 8'd0};
              pos_nxt = 2'd2;
              hs_nxt  = HS_NONE;
            end
            2'd1: begin
              acc_nxt = {8'd0, item.count_in, 16'd1};
              pos_nxt = 2'd3;
              hs_nxt  = HS_NONE;
            end
            2'd2: begin
              acc_nxt = {item.count_in, 24'd2};
              pos_nxt = 2'd0;
              hs_nxt  = HS_ACC_OUT;
            end
            default: begin
              acc_nxt = {24'd0, item.count_in};
              pos_nxt = 2'd1;
              hs_nxt  = HS_PAD_WORD;
            end
          endcase
          rem_nxt        = {1'b0, len_e};
          in_packet_nxt  = 1'b1;
          res_valid      = 1'b1;
          res.out_word   = item.random_value;
          res.byte_mask  = 4'hF;
        end else begin
          rem_nxt = (item.length > LENGTH_BITS'(4))
                    ? {1'b0, item.length - LENGTH_BITS'(4)} : '0;
          acc_nxt       = '0;
          pos_nxt       = 2'd0;
          hs_nxt        = HS_SALT;
          in_packet_nxt = 1'b1;
        end
      end else if (in_packet_r) begin
        if (mode_r == MODE_ENC) begin
          // a pending header word goes out ahead of the first payload byte
          if (hs_r == HS_ACC_OUT) begin
            res.out_word = rotl32(acc_r ^ mask_r, rot_r);
            acc_w        = '0;
            pos_w        = 2'd0;
            emitted      = 1'b1;
          end else if (hs_r == HS_PAD_WORD) begin
            res.out_word = rotl32(32'd3 ^ mask_r, rot_r);
            emitted      = 1'b1;
          end
          acc_w  = acc_w | ({24'd0, item.data_in[7:0]} << {pos_w, 3'b000});
          pos_w  = pos_w + 2'd1;
          rem_w  = (rem_r != '0) ? rem_r - REM_BITS'(1) : rem_r;
          if (pos_w == 2'd0 && !emitted) begin
            last_w       = (rem_w == '0);
            res.out_word = rotl32(acc_w ^ mask_r, rot_r);
            acc_w        = '0;
            emitted      = 1'b1;
            if (last_w) begin
              in_packet_nxt = 1'b0;
            end
          end
          res_valid     = emitted;
          res.byte_mask = 4'hF;
          res.last      = last_w;
          hs_nxt        = HS_NONE;
          acc_nxt       = acc_w;
          pos_nxt       = pos_w;
          rem_nxt       = rem_w;
        end else if (hs_r == HS_SALT) begin
          mask_nxt = 32'(rem_r) ^ xor_key_r ^ item.data_in;
          rot_nxt  = rem_r[4:0] ^ shift_key_r ^ item.data_in[4:0];
          hs_nxt   = HS_PAD_PEND;
          if (rem_r == '0) begin
            in_packet_nxt = 1'b0;
          end
        end else begin
          // first body word: pad, zero bytes, and count unless the pad is 3
          if (hs_r == HS_PAD_PEND) begin
            if (kd != 2'd3) begin
              acc_w  = {24'd0, 8'(dword >> {kd1, 3'b000})};
              hs_nxt = HS_NONE;
              unique case (kd)
                2'd0:    pm = 4'hC;
                2'd1:    pm = 4'h8;
                default: pm = 4'h0;
              endcase
            end else begin
              pm     = 4'h0;
              hs_nxt = HS_PAD_BYTE;
            end
          end else if (hs_r == HS_PAD_BYTE) begin
            acc_w  = {24'd0, dword[7:0]};
            pm     = 4'hE;
            hs_nxt = HS_NONE;
          end
          rem_w  = rem_r - REM_BITS'(nb);
          last_w = (rem_w == '0);
          if (last_w) begin
            in_packet_nxt = 1'b0;
          end
          acc_nxt       = acc_w;
          rem_nxt       = rem_w;
          res_valid     = 1'b1;
          res.out_word  = dword;
          res.byte_mask = pm & valid_m;
          res.count_out = acc_w[7:0];
          res.last      = last_w;
        end
      end
    end

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: begin
          mode_nxt      = cfg_data[0];
          in_packet_nxt = 1'b0;
        end
        CFG_XOR_KEY:   xor_key_nxt   = cfg_data;
        CFG_SHIFT_KEY: shift_key_nxt = cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_ENC;
      xor_key_r   <= '0;
      shift_key_r <= '0;
      acc_r       <= '0;
      pos_r       <= '0;
      rem_r       <= '0;
      mask_r      <= '0;
      rot_r       <= '0;
      hs_r        <= HS_NONE;
      in_packet_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      xor_key_r   <= xor_key_nxt;
      shift_key_r <= shift_key_nxt;
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      mask_r      <= mask_nxt;
      rot_r       <= rot_nxt;
      hs_r        <= hs_nxt;
      in_packet_r <= in_packet_nxt;
    end
  end

endmodule

// ----- sv/psc_out_reg.sv -----
// result register feeding the output stream
module psc_out_reg
  import psc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  logic    res_valid,
  input  result_t res,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ----- sv/packet_xor_rotate_scrambler_top.sv -----
// Packet xor/rotate scrambler: usage notes.
// Input stream in_*: in_tuser is the item kind (start of packet or data). On a
// start the payload length is taken, and in encode the salt word and count byte;
// on data the payload byte (encode) or packet word (decode) is taken from in_tdata.
// Output stream out_*: one word per result, with a byte mask and the recovered
// count byte in out_tdata, and out_tlast on the final word of a packet.
// Configuration: cfg_we with cfg_index 0 (mode), 1 (xor key), 2 (shift key);
// write only while idle. Writing the mode drops any packet in progress.
// Path: an item goes through an input register and a result register; the
// input register loads on the input transfer, and the result register takes
// the result when the output is free to advance.
// Throughput: one item per cycle while the output is not stalled; the per-item
// work is a single xor and rotate between the two registers. Items that give
// no result (decode salt word, encode bytes that do not close a word) still fire.
// A stalled output holds its word; the input register keeps taking items
// until both registers are full, then in_tready drops.
// Reset (synchronous, rst_n low) clears the keys, the mode to encode and
// leaves the block idle with no packet open.
module packet_xor_rotate_scrambler_top
  import psc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // length, random_value, count_in, data_in
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_word, byte_mask, count_out, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.op           = in_tuser;
  assign in_item.length       = in_tdata[LENGTH_BITS-1:0];
  assign in_item.random_value = in_tdata[LENGTH_BITS +: 32];
  assign in_item.count_in     = in_tdata[LENGTH_BITS+32 +: 8];
  assign in_item.data_in      = in_tdata[LENGTH_BITS+40 +: 32];

  assign advance   = !out_tvalid || out_tready;
  assign fire      = item_valid && advance;
  assign in_tready = !item_valid || advance;

  psc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_tready),
    .in_valid   (in_tvalid),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item)
  );

  psc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  psc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_valid (fire && res_valid),
    .res       (res),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  assign out_tdata = {4'd0, out_res.count_out, out_res.byte_mask, out_res.out_word};
  assign out_tlast = out_res.last;

endmodule

// ----- bench/packet_xor_rotate_scrambler_top_test.sv -----
// self-checking bench for the packet scrambler: directed table, then random packets
module packet_xor_rotate_scrambler_top_test;
  import psc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int SEG_ITEMS      = 95;

  // how a directed row is checked
  localparam logic [1:0] CHK_PRED = 2'd0;
  localparam logic [1:0] CHK_NONE = 2'd1;
  localparam logic [1:0] CHK_RES  = 2'd2;

  // for a register write the value rides in it.data_in
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    item_t                it;
    logic [1:0]           chk;
    result_t              res;
  } step_t;

  localparam int PLAN_LEN = 29;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // predictor copy of registers and packet state
  logic                   mode_r = MODE_ENC;
  logic [31:0]            xkey_r = '0;
  logic [4:0]             skey_r = '0;
  logic [31:0]            acc    = '0;
  logic [1:0]             bpos   = '0;
  logic [REM_BITS-1:0]    remain = '0;
  logic [31:0]            pmask  = '0;
  logic [4:0]             prot   = '0;
  logic [2:0]             hskip  = HS_NONE;
  logic                   open_r = 1'b0;

  result_t pending_words[$];
  int      mismatches   = 0;
  int      send_idle    = 0;
  int      recv_idle    = 0;
  int      sent_items   = 0;
  int      idle_cycles  = 0;
  bit      hold_pending = 1'b0;

  step_t plan [PLAN_LEN] = '{
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0000, 32'h0, 8'h00, 32'hFFFFFFFF}, CHK_NONE, '0},
    // zero length counts as one payload byte
    '{1'b0, CFG_MODE, '{OP_START, 16'h0000, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF}, CHK_RES,
      '{32'hFFFFFFFF, 4'hF, 8'h00, 1'b0}},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF}, CHK_PRED, '0},
    '{1'b0, CFG_MODE, '{OP_START, 16'hFFFF, 32'h0, 8'h00, 32'h0}, CHK_RES,
      '{32'h0, 4'hF, 8'h00, 1'b0}},
    // three pad bytes: pad word leaves on the first payload byte, then restart mid packet
    '{1'b0, CFG_MODE, '{OP_DATA, 16'hFFFF, 32'h0, 8'h00, 32'h0}, CHK_PRED, '0},
    // body length 4 xor salt 4 gives rotate zero and mask zero
    '{1'b0, CFG_MODE, '{OP_START, 16'h0002, 32'h00000004, 8'h5A, 32'h0}, CHK_RES,
      '{32'h00000004, 4'hF, 8'h00, 1'b0}},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h00000011}, CHK_NONE, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'hFFFFFF22}, CHK_RES,
      '{32'h22115A00, 4'hF, 8'h00, 1'b1}},
    '{1'b0, CFG_MODE, '{OP_START, 16'h0004, 32'hA5A5A5A5, 8'h80, 32'h0}, CHK_RES,
      '{32'hA5A5A5A5, 4'hF, 8'h00, 1'b0}},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h00000001}, CHK_PRED, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h00000002}, CHK_PRED, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h00000003}, CHK_PRED, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h00000004}, CHK_PRED, '0},
    '{1'b1, CFG_XOR_KEY, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'hFFFFFFFF}, CHK_NONE, '0},
    '{1'b1, CFG_SHIFT_KEY, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h0000001F}, CHK_NONE, '0},
    '{1'b0, CFG_MODE, '{OP_START, 16'h0003, 32'h0, 8'h01, 32'h0}, CHK_RES,
      '{32'h0, 4'hF, 8'h00, 1'b0}},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h0000007F}, CHK_PRED, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h00000080}, CHK_PRED, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h000000FE}, CHK_PRED, '0},
    '{1'b1, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, {31'd0, MODE_DEC}}, CHK_NONE, '0},
    // short packet: salt only, no body
    '{1'b0, CFG_MODE, '{OP_START, 16'h0004, 32'h0, 8'h00, 32'h0}, CHK_NONE, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h12345678}, CHK_NONE, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'hFFFFFFFF}, CHK_NONE, '0},
    '{1'b0, CFG_MODE, '{OP_START, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 32'h0}, CHK_NONE, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'hFFFFFFFF}, CHK_NONE, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h0}, CHK_PRED, '0},
    // partial last word of three bytes, all of them header, so the mask is empty
    '{1'b0, CFG_MODE, '{OP_START, 16'h0007, 32'h0, 8'h00, 32'h0}, CHK_NONE, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'h5A5A5A5A}, CHK_NONE, '0},
    '{1'b0, CFG_MODE, '{OP_DATA, 16'h0, 32'h0, 8'h00, 32'hC3C3C3C3}, CHK_PRED, '0}
  };

  always #4 clk = ~clk;

  packet_xor_rotate_scrambler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  function automatic logic [31:0] rol(input logic [31:0] w, input logic [4:0] r);
    return (w << r) | (w >> (6'd32 - r));
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] w, input logic [4:0] r);
    return (w >> r) | (w << (6'd32 - r));
  endfunction

  function automatic item_t rand_item(input logic op, input logic [15:0] len);
    item_t it;
    it.op           = op;
    it.length       = len;
    it.random_value = $urandom;
    it.count_in     = $urandom;
    it.data_in      = $urandom;
    return it;
  endfunction

  task automatic scramble_step(input item_t it, output bit has, output result_t r);
    logic [REM_BITS-1:0] plen;
    logic [1:0]          pad;
    logic [31:0]         body;
    logic [31:0]         d;
    logic [2:0]          nb;
    logic [3:0]          valid;
    logic [3:0]          pm;
    logic                fin;
    has = 1'b0;
    r   = '0;
    if (it.op == OP_START) begin
      if (mode_r == MODE_ENC) begin
        plen  = (it.length == 0) ? REM_BITS'(1) : REM_BITS'(it.length);
        pad   = 2'd0 - (plen[1:0] + 2'd2);
        body  = 32'(plen) + 32'(pad) + 32'd2;
        pmask = body ^ xkey_r ^ it.random_value;
        prot  = body[4:0] ^ skey_r ^ it.random_value[4:0];
        case (pad)
          2'd0: begin
            acc = {16'd0, it.count_in, 8'd0}; bpos = 2'd2; hskip = HS_NONE;
          end
          2'd1: begin
            acc = {8'd0, it.count_in, 16'd1}; bpos = 2'd3; hskip = HS_NONE;
          end
          2'd2: begin
            acc = {it.count_in, 24'd2}; bpos = 2'd0; hskip = HS_ACC_OUT;
          end
          default: begin
            acc = {24'd0, it.count_in}; bpos = 2'd1; hskip = HS_PAD_WORD;
          end
        endcase
        remain = plen;
        open_r = 1'b1;
        has    = 1'b1;
        r      = '{it.random_value, 4'hF, 8'd0, 1'b0};
      end else begin
        remain = (it.length > 4) ? REM_BITS'(it.length - 16'd4) : '0;
        acc    = '0;
        bpos   = '0;
        hskip  = HS_SALT;
        open_r = 1'b1;
      end
    end else if (open_r && mode_r == MODE_ENC) begin
      // a pending header word leaves before the byte is merged
      if (hskip == HS_ACC_OUT) begin
        r    = '{rol(acc ^ pmask, prot), 4'hF, 8'd0, 1'b0};
        has  = 1'b1;
        acc  = '0;
        bpos = '0;
      end else if (hskip == HS_PAD_WORD) begin
        r   = '{rol(32'd3 ^ pmask, prot), 4'hF, 8'd0, 1'b0};
        has = 1'b1;
      end
      hskip = HS_NONE;
      acc   = acc | (32'(it.data_in[7:0]) << (8 * bpos));
      bpos  = bpos + 2'd1;
      if (remain != 0) remain = remain - 1'b1;
      if (bpos == 0 && !has) begin
        fin = (remain == 0);
        r   = '{rol(acc ^ pmask, prot), 4'hF, 8'd0, fin};
        has = 1'b1;
        acc = '0;
        if (fin) open_r = 1'b0;
      end
    end else if (open_r) begin
      if (hskip == HS_SALT) begin
        pmask = 32'(remain) ^ xkey_r ^ it.data_in;
        prot  = remain[4:0] ^ skey_r ^ it.data_in[4:0];
        hskip = HS_PAD_PEND;
        if (remain == 0) open_r = 1'b0;
      end else begin
        d     = ror(it.data_in, prot) ^ pmask;
        nb    = (remain >= 4) ? 3'd4 : remain[2:0];
        valid = 4'((5'd1 << nb) - 5'd1);
        pm    = 4'hF;
        if (hskip == HS_PAD_PEND) begin
          // pad of three puts the count in the next word
          if (d[1:0] != 2'd3) begin
            acc   = (d >> (8 * (d[1:0] + 1))) & 32'hFF;
            pm    = 4'(6'h0F << (d[1:0] + 3'd2));
            hskip = HS_NONE;
          end else begin
            pm    = 4'h0;
            hskip = HS_PAD_BYTE;
          end
        end else if (hskip == HS_PAD_BYTE) begin
          acc   = {24'd0, d[7:0]};
          pm    = 4'hE;
          hskip = HS_NONE;
        end
        remain = remain - nb;
        fin    = (remain == 0);
        if (fin) open_r = 1'b0;
        r   = '{d, pm & valid, acc[7:0], fin};
        has = 1'b1;
      end
    end
  endtask

  task automatic send_item(input item_t it, input logic [1:0] chk, input result_t typed);
    bit      has;
    result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= IN_TDATA_W'({it.data_in, it.count_in, it.random_value, it.length});
    do @(posedge clk); while (!in_tready);
    scramble_step(it, has, r);
    if (chk == CHK_RES) pending_words.push_back(typed);
    else if (chk == CHK_PRED && has) pending_words.push_back(r);
    sent_items++;
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  // stop offering and let every outstanding transfer finish
  task automatic settle();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MODE: begin
        mode_r = val[0];
        open_r = 1'b0;
      end
      CFG_XOR_KEY:   xkey_r = val;
      CFG_SHIFT_KEY: skey_r = val[4:0];
      default: ;
    endcase
  endtask

  task automatic encode_packet();
    int sel;
    int len;
    int n;
    sel = $urandom_range(31);
    if (sel == 0) len = 0;
    else if (sel <= 2) len = $urandom_range(65535);
    else if (sel <= 5) len = $urandom_range(64, 13);
    else len = $urandom_range(12, 1);
    n = (len == 0) ? 1 : len;
    // long packets are cut short by the next start, as are a few short ones
    if (n > 64 || $urandom_range(9) == 0) n = $urandom_range((n < 8) ? n : 8, 0);
    send_item(rand_item(OP_START, 16'(len)), CHK_PRED, '0);
    repeat (n) send_item(rand_item(OP_DATA, 16'($urandom)), CHK_PRED, '0);
    if ($urandom_range(11) == 0) send_item(rand_item(OP_DATA, 16'($urandom)), CHK_PRED, '0);
  endtask

  task automatic decode_packet();
    int sel;
    int len;
    int n;
    sel = $urandom_range(31);
    if (sel == 0) len = $urandom_range(4);
    else if (sel <= 2) len = $urandom_range(65535);
    else if (sel <= 6) len = $urandom_range(96, 25);
    else len = $urandom_range(24, 5);
    n = (len + 3) / 4;
    if (n == 0) n = 1;
    if (n > 24 || $urandom_range(9) == 0) n = $urandom_range((n < 8) ? n : 8, 0);
    send_item(rand_item(OP_START, 16'(len)), CHK_PRED, '0);
    repeat (n) send_item(rand_item(OP_DATA, 16'($urandom)), CHK_PRED, '0);
    if ($urandom_range(11) == 0) send_item(rand_item(OP_DATA, 16'($urandom)), CHK_PRED, '0);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %h last %b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("out_word", want.out_word, out_tdata[31:0]);
        check_field("byte_mask", 32'(want.byte_mask), 32'(out_tdata[35:32]));
        check_field("count_out", 32'(want.count_out), 32'(out_tdata[43:36]));
        check_field("last", 32'(want.last), 32'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          seg_end;
    int          setting;
    logic [31:0] xkey;
    logic [31:0] skey;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].it.data_in);
      end else begin
        send_item(plan[i].it, plan[i].chk, plan[i].res);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 38 : (phase == 1) ? 59 : 0;
      recv_idle = (phase == 0) ? 59 : (phase == 1) ? 38 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        settle();
        setting = phase * 4 + seg;
        xkey = $urandom;
        skey = $urandom_range(31);
        if (setting == 0) begin
          xkey = '0;
          skey = '0;
        end else if (setting == 5 || setting == 10) begin
          xkey = 32'hFFFFFFFF;
          skey = 32'd31;
        end
        write_reg(CFG_MODE, {31'd0, (seg % 2 == 0) ? MODE_ENC : MODE_DEC});
        write_reg(CFG_XOR_KEY, xkey);
        write_reg(CFG_SHIFT_KEY, skey);
        // back-to-back offers against a stalled output
        if (phase == 2 && seg == 1) hold_pending = 1'b1;
        seg_end = sent_items + SEG_ITEMS;
        while (sent_items < seg_end) begin
          if (mode_r == MODE_ENC) encode_packet();
          else decode_packet();
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
